@@ rtl/core/hcfr_pkg.sv @@
// Package for the hex command frame receiver: payload structs, the command
// passed from front to back, character constants and the hex pair decoder.
// No dependencies.
`default_nettype none

package hcfr_pkg;

  localparam logic [7:0] CHAR_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CHAR_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOW_F  = 8'h66;  // 'f'
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  localparam logic [0:0] KIND_BYTE = 1'b0;
  localparam logic [0:0] KIND_TICK = 1'b1;

  localparam int STORE_DEPTH = 26;
  localparam int IDX_W       = 5;
  localparam int COUNT_W     = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  localparam int LED_W = 9;
  localparam int OFF_W = 10;
  localparam logic [LED_W-1:0] LED_LAST = 9'd499;   // heartbeat period 500
  localparam logic [OFF_W-1:0] OFF_LAST = 10'd699;  // trigger release period 700

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [7:0]  mode_byte;
    logic [7:0]  addr_first;
    logic [7:0]  addr_second;
    logic [7:0]  addr_third;
    logic [7:0]  config_byte;
    logic [63:0] payload;
    logic        led_level;
    logic        trigger_level;
  } result_t;

  // One classified item, as handed from the front to the back.
  typedef struct packed {
    logic             tick;
    logic             clear;
    logic             arm;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_byte;
    logic             close_ok;
  } cmd_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
      v = c - CHAR_LOW_A + 8'd10;
    end else begin
      v = c - CHAR_ZERO;
    end
    return v;
  endfunction

  // Low nibble of the high digit moved to the upper nibble, OR the whole low digit.
  function automatic logic [7:0] pair_decode(input logic [7:0] hi_c, input logic [7:0] lo_c);
    logic [7:0] h;
    logic [7:0] l;
    h = digit_value(hi_c);
    l = digit_value(lo_c);
    return {h[3:0], 4'h0} | l;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hex_command_frame_receiver.sv @@
// Hex command frame receiver, top level: front classifier, command queue,
// back executor and result queue. Depends on hcfr_pkg, hcfr_fifo,
// hcfr_front and hcfr_back.
//
// Each input item is a received UART byte or one timer tick; each item
// gives exactly one result, in order. A '#' while idle opens a frame and
// clears the 26-character store; bytes up to and including the closing
// '$' are stored by position. A frame with no zero byte and a length of
// at most LENGTH_LIMIT returns frame_valid with thirteen bytes decoded from
// the hex pairs at positions 1 to 26; every result also carries the LED and
// trigger levels. One item is taken per clock while full is low: the back
// stage executes one command per cycle while the result queue has room;
// each command is registered in the command queue, and its result in the
// result queue, before it can be popped. Each queue holds QUEUE_DEPTH entries;
// while the result side stalls, full rises at 2*QUEUE_DEPTH waiting items.
`default_nettype none

module hex_command_frame_receiver
  import hcfr_pkg::*;
#(
  parameter int LENGTH_LIMIT = 50,
  parameter int QUEUE_DEPTH  = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  logic       accept;
  cmd_t       front_cmd;
  cmd_t       back_cmd;
  logic [CMD_W-1:0] back_cmd_bits;
  logic       cmd_full;
  logic       cmd_empty;
  logic       cmd_pop;
  logic       res_full;
  logic       res_push;
  result_t    back_res;
  logic [RES_W-1:0] result_bits;

  // Take an item whenever the command queue has room.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Classify and advance frame position at transfer time.
  hcfr_front #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .cmd   (front_cmd)
  );

  // Hold classified commands so the back can stall on its own.
  hcfr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(front_cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (back_cmd_bits),
    .empty    (cmd_empty)
  );

  assign back_cmd = cmd_t'(back_cmd_bits);

  // Execute one command per cycle while the result queue has room.
  hcfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd      (back_cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  // Present the oldest result until it is popped.
  hcfr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(back_res),
    .full     (res_full),
    .pop      (pop),
    .pop_data (result_bits),
    .empty    (empty)
  );

  assign result = result_t'(result_bits);

endmodule

`default_nettype wire

@@ rtl/core/hcfr_fifo.sv @@
// Small first-in first-out queue of flat words, used between front and back
// and in front of the result ports. No dependencies.
`default_nettype none

module hcfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_COUNT = (AW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hcfr_front.sv @@
// Front of the receiver: tracks the frame position and zero flag and turns
// each transferred item into a command. Depends on hcfr_pkg.
`default_nettype none

module hcfr_front
  import hcfr_pkg::*;
#(
  parameter int LENGTH_LIMIT = 50
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire item_t item,
  output cmd_t       cmd
);

  // Length is count minus one, so accept while count is at most limit plus one.
  localparam logic [COUNT_W-1:0] CLOSE_MAX = COUNT_W'(LENGTH_LIMIT + 1);
  localparam logic [COUNT_W-1:0] STORE_LAST = COUNT_W'(STORE_DEPTH);

  logic [COUNT_W-1:0] frame_count;
  logic [COUNT_W-1:0] frame_count_next;
  logic               zero_seen;
  logic               zero_seen_next;

  always_comb begin
    cmd              = '0;
    cmd.wr_byte      = item.rx_byte;
    cmd.wr_idx       = IDX_W'(frame_count - 1'b1);
    frame_count_next = frame_count;
    zero_seen_next   = zero_seen;
    if (item.kind == KIND_TICK) begin
      cmd.tick = 1'b1;
    end else if (frame_count == '0) begin
      if (item.rx_byte == CHAR_HASH) begin
        cmd.clear        = 1'b1;
        zero_seen_next   = 1'b0;
        frame_count_next = COUNT_W'(1);
      end else if (item.rx_byte == CHAR_STAR) begin
        cmd.arm = 1'b1;
      end
    end else begin
      cmd.wr_en = (frame_count <= STORE_LAST);
      if (item.rx_byte == CHAR_DOLLAR) begin
        cmd.close_ok     = !zero_seen && (frame_count <= CLOSE_MAX);
        frame_count_next = '0;
      end else begin
        if (item.rx_byte == CHAR_NUL) begin
          zero_seen_next = 1'b1;
        end
        if (frame_count < COUNT_MAX) begin
          frame_count_next = frame_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      zero_seen   <= 1'b0;
    end else if (accept) begin
      frame_count <= frame_count_next;
      zero_seen   <= zero_seen_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hcfr_back.sv @@
// Back of the receiver: executes commands against the character store, the
// tick counters, LED and trigger, and builds one result per command.
// Depends on hcfr_pkg.
`default_nettype none

module hcfr_back
  import hcfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_empty,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  input  wire logic res_full,
  output logic      res_push,
  output result_t   res
);

  logic [7:0]       store      [STORE_DEPTH];
  logic [7:0]       store_next [STORE_DEPTH];
  logic [31:0]      tick_count;
  logic [31:0]      tick_count_next;
  logic [LED_W-1:0] led_phase;
  logic [LED_W-1:0] led_phase_next;
  logic [OFF_W-1:0] off_phase;
  logic [OFF_W-1:0] off_phase_next;
  logic             led_on;
  logic             led_on_next;
  logic             trigger_armed;
  logic             trigger_armed_next;
  logic             trigger_out;
  logic             trigger_out_next;
  logic             wraps;

  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop;

  // Store after this command: clear on frame open, then merge the write.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_next[i] = cmd.clear ? 8'h00 : store[i];
      if (cmd.wr_en && cmd.wr_idx == IDX_W'(i)) begin
        store_next[i] = cmd.wr_byte;
      end
    end
  end

  // Phases track tick_count mod 500 and mod 700; the 32-bit wrap lands on zero.
  assign wraps = (tick_count == 32'hFFFF_FFFF);

  always_comb begin
    tick_count_next    = tick_count;
    led_phase_next     = led_phase;
    off_phase_next     = off_phase;
    led_on_next        = led_on;
    trigger_armed_next = trigger_armed;
    trigger_out_next   = trigger_out;
    if (cmd.tick) begin
      tick_count_next = tick_count + 32'd1;
      led_phase_next  = (wraps || led_phase == LED_LAST) ? '0 : led_phase + 1'b1;
      off_phase_next  = (wraps || off_phase == OFF_LAST) ? '0 : off_phase + 1'b1;
      if (led_phase_next == '0) begin
        led_on_next = !led_on;
      end
      if (trigger_armed) begin
        if (led_phase_next == '0) begin
          trigger_out_next = 1'b1;
        end
        if (off_phase_next == '0) begin
          trigger_out_next   = 1'b0;
          trigger_armed_next = 1'b0;
        end
      end
    end
    if (cmd.arm) begin
      trigger_armed_next = 1'b1;
    end
  end

  always_comb begin
    res = '0;
    if (cmd.close_ok) begin
      res.frame_valid = 1'b1;
      res.mode_byte   = pair_decode(store_next[0], store_next[1]);
      res.addr_first  = pair_decode(store_next[2], store_next[3]);
      res.addr_second = pair_decode(store_next[4], store_next[5]);
      res.addr_third  = pair_decode(store_next[6], store_next[7]);
      res.config_byte = pair_decode(store_next[8], store_next[9]);
      for (int k = 0; k < 8; k++) begin
        res.payload[63 - 8*k -: 8] = pair_decode(store_next[10 + 2*k], store_next[11 + 2*k]);
      end
    end
    res.led_level     = led_on_next;
    res.trigger_level = trigger_out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] <= 8'h00;
      end
      tick_count    <= '0;
      led_phase     <= '0;
      off_phase     <= '0;
      led_on        <= 1'b0;
      trigger_armed <= 1'b0;
      trigger_out   <= 1'b0;
    end else if (cmd_pop) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] <= store_next[i];
      end
      tick_count    <= tick_count_next;
      led_phase     <= led_phase_next;
      off_phase     <= off_phase_next;
      led_on        <= led_on_next;
      trigger_armed <= trigger_armed_next;
      trigger_out   <= trigger_out_next;
    end
  end

  a_trigger_needs_arm: assert property (@(posedge clk) disable iff (rst)
    trigger_out |-> trigger_armed)
    else $error("trigger high while not armed");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (led_phase <= LED_LAST) && (off_phase <= OFF_LAST))
    else $error("tick phase counter out of range");

  a_led_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(cmd_pop && cmd.tick) |=> $stable(led_on))
    else $error("LED changed without a tick");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for hex_command_frame_receiver: directed and random
// UART bytes and timer ticks go in, and every result is checked against a
// built-in model of the receiver. Depends on hcfr_pkg and the RTL top level.
`default_nettype none

module testbench;
  import hcfr_pkg::*;

  localparam int FRAME_LIMIT    = 50;
  localparam int RANDOM_ITEMS   = 380;   // stop adding items once this many are queued
  localparam int TAIL_CYCLES    = 16;    // drain time after the last expected result
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int LED_PERIOD     = 500;
  localparam int TRIG_OFF       = 700;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  result_t result;

  hex_command_frame_receiver #(
    .LENGTH_LIMIT(FRAME_LIMIT)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Items waiting to be driven, and results the receiver owes us.
  item_t   pending_items[$];
  result_t expected_results[$];

  int sent_count  = 0;
  int total_items = 0;
  int error_count = 0;
  int stall_count = 0;

  // Coverage tallies for the closing summary.
  int frames_accepted = 0;
  int frames_rejected = 0;
  int led_toggles     = 0;
  int trigger_rises   = 0;

  // Mirror of the receiver state.
  logic [COUNT_W-1:0] frame_pos;
  logic [7:0]         char_mem [STORE_DEPTH];
  logic               nul_seen;
  logic [31:0]        tick_total;
  logic               heartbeat;
  logic               trig_armed;
  logic               trig_state;

  // Split the run into four idling phases by how many items have gone in.
  int sender_idle_pct;
  int receiver_stall_pct;
  always_comb begin
    case ((total_items == 0) ? 0 : (sent_count * 4) / total_items)
      1: begin
        sender_idle_pct    = 45;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 45;
      end
      3: begin
        sender_idle_pct    = 21;
        receiver_stall_pct = 21;
      end
      default: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
    endcase
  end

  // ASCII hex digit value: lowercase a-f are 10-15, anything else is c - '0'
  // taken modulo 256.
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "a" && c <= "f") begin
      v = c - 8'd87;
    end else begin
      v = c - 8'd48;
    end
    return v;
  endfunction

  // Byte built from two stored characters; the upper nibble of the high digit
  // is shifted out of range above bit 7 and dropped.
  function automatic logic [7:0] hex_pair(input int pos);
    logic [11:0] wide;
    wide = {hex_digit(char_mem[pos - 1]), 4'h0} | {4'h0, hex_digit(char_mem[pos])};
    return wide[7:0];
  endfunction

  function automatic void reset_receiver_model();
    frame_pos  = '0;
    nul_seen   = 1'b0;
    tick_total = '0;
    heartbeat  = 1'b0;
    trig_armed = 1'b0;
    trig_state = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      char_mem[i] = 8'h00;
    end
  endfunction

  // Advance the model by one transferred item and queue the result it owes.
  task automatic advance_receiver(input item_t it);
    result_t want;
    logic    accept;
    want   = '0;
    accept = 1'b0;
    if (it.kind == KIND_TICK) begin
      tick_total = tick_total + 32'd1;
      if (tick_total % LED_PERIOD == 0) begin
        heartbeat = ~heartbeat;
        led_toggles++;
      end
      if (trig_armed) begin
        if (tick_total % LED_PERIOD == 0) begin
          trig_state = 1'b1;
          trigger_rises++;
        end
        if (tick_total % TRIG_OFF == 0) begin
          trig_state = 1'b0;
          trig_armed = 1'b0;
        end
      end
    end else if (frame_pos == 0) begin
      // Idle: only an opening hash or a star does anything.
      if (it.rx_byte == CHAR_HASH) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          char_mem[i] = 8'h00;
        end
        nul_seen  = 1'b0;
        frame_pos = 7'd1;
      end else if (it.rx_byte == CHAR_STAR) begin
        trig_armed = 1'b1;
      end
    end else begin
      // Inside a frame every byte up to position STORE_DEPTH is kept, the closing dollar included.
      if (frame_pos <= STORE_DEPTH) begin
        char_mem[frame_pos - 1] = it.rx_byte;
      end
      if (it.rx_byte == CHAR_DOLLAR) begin
        accept    = !nul_seen && (int'(frame_pos) - 1 <= FRAME_LIMIT);
        frame_pos = '0;
        if (accept) begin
          frames_accepted++;
        end else begin
          frames_rejected++;
        end
      end else begin
        if (it.rx_byte == CHAR_NUL) begin
          nul_seen = 1'b1;
        end
        if (frame_pos != COUNT_MAX) begin
          frame_pos = frame_pos + 7'd1;
        end
      end
    end
    if (accept) begin
      want.frame_valid = 1'b1;
      want.mode_byte   = hex_pair(1);
      want.addr_first  = hex_pair(3);
      want.addr_second = hex_pair(5);
      want.addr_third  = hex_pair(7);
      want.config_byte = hex_pair(9);
      for (int k = 0; k < 8; k++) begin
        want.payload = {want.payload[55:0], hex_pair(11 + 2 * k)};
      end
    end
    want.led_level     = heartbeat;
    want.trigger_level = trig_state;
    expected_results.push_back(want);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Driver: present the head of the pending queue; hold it while full.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        advance_receiver(item);
        pending_items.delete(0);
        sent_count++;
      end
      if (push && full) begin
        // hold the item until the receiver takes it
      end else if (pending_items.size() > 0 &&
                   $urandom_range(0, 99) >= sender_idle_pct) begin
        push <= 1'b1;
        item <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: frame_valid %0b", result.frame_valid);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("frame_valid",   want.frame_valid,   result.frame_valid);
          check_field("mode_byte",     want.mode_byte,     result.mode_byte);
          check_field("addr_first",    want.addr_first,    result.addr_first);
          check_field("addr_second",   want.addr_second,   result.addr_second);
          check_field("addr_third",    want.addr_third,    result.addr_third);
          check_field("config_byte",   want.config_byte,   result.config_byte);
          check_field("payload",       want.payload,       result.payload);
          check_field("led_level",     want.led_level,     result.led_level);
          check_field("trigger_level", want.trigger_level, result.trigger_level);
        end
      end
      pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Watchdog: end the run when neither side has moved for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_count <= 0;
    end else if (stall_count + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d items pending, %0d results owed",
               pending_items.size(), expected_results.size());
      $display("simulation failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    pending_items.push_back('{kind: KIND_BYTE, rx_byte: b});
  endtask

  // A tick carries a random, unused byte so its bits still toggle.
  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      pending_items.push_back('{kind: KIND_TICK, rx_byte: 8'($urandom)});
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endtask

  // Mostly lowercase hex digits; now and then any byte except the closing
  // dollar and zero, which are placed on purpose only.
  function automatic logic [7:0] frame_char();
    string      digits;
    logic [7:0] c;
    digits = "0123456789abcdef";
    if ($urandom_range(0, 99) < 80) begin
      c = digits[$urandom_range(0, 15)];
    end else begin
      c = 8'($urandom);
      if (c == CHAR_DOLLAR) begin
        c = 8'h25;
      end else if (c == CHAR_NUL) begin
        c = 8'hFF;
      end
    end
    return c;
  endfunction

  // Open a frame, fill len bytes (a zero at nul_at if in range), close it
  // when asked.
  task automatic add_frame(input int len, input int nul_at, input logic close);
    add_byte(CHAR_HASH);
    for (int i = 0; i < len; i++) begin
      add_byte((i == nul_at) ? CHAR_NUL : frame_char());
    end
    if (close) begin
      add_byte(CHAR_DOLLAR);
    end
  endtask

  initial begin
    int pick;
    int len;
    int n;

    reset_receiver_model();

    // Directed: idle noise at both byte extremes, a tick, arming, the empty
    // frame, a zero byte, mixed-case digits, hash and star inside a frame.
    add_ticks(1);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CHAR_STAR);
    add_text("#$");
    add_text("#");
    add_byte(CHAR_NUL);
    add_text("$");
    add_text("#fF09a$");
    add_text("##*$");
    add_text("*#");
    add_byte(8'hFF);
    add_text("$");

    // Random: mostly well-formed frames with random content, mixed with
    // short tick bursts, idle noise, stars, fragments and overlong frames.
    while (pending_items.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n = $urandom_range(0, 99);
        if (n < 10) begin
          len = FRAME_LIMIT;
        end else if (n < 20) begin
          len = FRAME_LIMIT + 1;
        end else if (n < 60) begin
          len = $urandom_range(20, 28);
        end else begin
          len = $urandom_range(0, FRAME_LIMIT);
        end
        add_frame(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1, 1'b1);
      end else if (pick < 70) begin
        n = $urandom_range(1, 40);
        add_ticks(n);
      end else if (pick < 80) begin
        // idle noise the receiver ignores, unless it happens to be a hash or a star
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          add_byte(8'($urandom));
        end
      end else if (pick < 88) begin
        add_byte(CHAR_STAR);
      end else if (pick < 94) begin
        // unclosed fragment: whatever follows lands inside this frame
        len = $urandom_range(0, 12);
        add_frame(len, -1, 1'b0);
      end else begin
        // overlong frame: the position count may saturate, and it is rejected
        len = $urandom_range(120, 140);
        add_frame(len, -1, 1'b1);
      end
    end
    total_items = pending_items.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, every result back, then a short tail to catch
    // any extra result.
    while (pending_items.size() != 0 || push || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end

    $display("run covered %0d items: %0d frames accepted, %0d rejected, %0d ticks",
             sent_count, frames_accepted, frames_rejected, tick_total);
    $display("heartbeat toggled %0d times, trigger raised %0d times",
             led_toggles, trigger_rises);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
